>>> rtl/smt_pkg.sv
// Package for the sorted multiset table: request, status, state and cell operation
// codes, cell control bundle and default sizes. No dependencies.
`default_nettype none

package smt_pkg;

  localparam int DEF_TABLE_DEPTH = 32;
  localparam int DEF_VALUE_BITS  = 32;
  localparam int DEF_REPEAT_BITS = 16;

  // Width of the input value word and of the action code
  localparam int IN_VALUE_W = 32;
  localparam int ACTION_W   = 2;
  localparam int STATUS_W   = 2;

  typedef enum logic [ACTION_W-1:0] {
    ACT_INSERT = 2'd0,
    ACT_DELETE = 2'd1,
    ACT_FIND   = 2'd2,
    ACT_SPARE  = 2'd3
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE       = 2'd0,
    ST_DEL_ABSENT = 2'd1,
    ST_FULL       = 2'd2,
    ST_SATURATED  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_CMP  = 2'd1,
    S_UPD  = 2'd2
  } state_t;

  typedef enum logic [2:0] {
    OP_HOLD   = 3'd0,
    OP_INSERT = 3'd1,
    OP_REMOVE = 3'd2,
    OP_INC    = 3'd3,
    OP_DEC    = 3'd4
  } cell_op_t;

  typedef struct packed {
    logic     cmp_en;
    cell_op_t op;
  } cell_ctl_t;

endpackage

`default_nettype wire

>>> rtl/smt_cell.sv
// One slot of the sorted table: stored value and repeat count, compare flags,
// and the shift/update step. Depends on smt_pkg.
`default_nettype none

module smt_cell #(
  parameter int INDEX       = 0,
  parameter int VALUE_BITS  = 32,
  parameter int REPEAT_BITS = 16,
  parameter int CNT_W       = 6
) (
  input  wire                     clk,
  input  smt_pkg::cell_ctl_t      ctl,
  input  wire  [VALUE_BITS-1:0]   req_value,
  input  wire  [CNT_W-1:0]        used_count,
  input  wire  [VALUE_BITS-1:0]   left_value,
  input  wire  [REPEAT_BITS-1:0]  left_repeats,
  input  wire                     left_lt,
  input  wire  [VALUE_BITS-1:0]   right_value,
  input  wire  [REPEAT_BITS-1:0]  right_repeats,
  output logic [VALUE_BITS-1:0]   cell_value,
  output logic [REPEAT_BITS-1:0]  cell_repeats,
  output logic                    lt,
  output logic                    eq,
  output logic [REPEAT_BITS-1:0]  hit_repeats
);
  import smt_pkg::*;

  logic [VALUE_BITS-1:0]  value_r,   value_nxt;
  logic [REPEAT_BITS-1:0] repeats_r, repeats_nxt;
  logic                   lt_r, eq_r;
  logic [REPEAT_BITS-1:0] hit_r;
  logic                   used;

  assign used = used_count > CNT_W'(INDEX);

  always_comb begin
    value_nxt   = value_r;
    repeats_nxt = repeats_r;
    case (ctl.op)
      OP_INSERT: begin
        // slots below the insertion point keep, the point loads, above shift up
        if (!lt_r) begin
          if (left_lt) begin
            value_nxt   = req_value;
            repeats_nxt = '0;
          end else begin
            value_nxt   = left_value;
            repeats_nxt = left_repeats;
          end
        end
      end
      OP_REMOVE: begin
        if (!lt_r) begin
          value_nxt   = right_value;
          repeats_nxt = right_repeats;
        end
      end
      OP_INC: begin
        if (eq_r) repeats_nxt = repeats_r + REPEAT_BITS'(1);
      end
      OP_DEC: begin
        if (eq_r) repeats_nxt = repeats_r - REPEAT_BITS'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    value_r   <= value_nxt;
    repeats_r <= repeats_nxt;
    if (ctl.cmp_en) begin
      lt_r  <= used && ($signed(value_r) < $signed(req_value));
      eq_r  <= used && (value_r == req_value);
      hit_r <= (used && (value_r == req_value)) ? repeats_r : '0;
    end
  end

  assign cell_value   = value_r;
  assign cell_repeats = repeats_r;
  assign lt           = lt_r;
  assign eq           = eq_r;
  assign hit_repeats  = hit_r;

endmodule

`default_nettype wire

>>> rtl/smt_ctrl.sv
// Request sequencer for the sorted table: handshakes, request and count
// registers, result decision and output register. Depends on smt_pkg.
`default_nettype none

module smt_ctrl #(
  parameter int TABLE_DEPTH = 32,
  parameter int VALUE_BITS  = 32,
  parameter int REPEAT_BITS = 16,
  parameter int CNT_W       = 6
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_stall,
  input  wire  [smt_pkg::ACTION_W-1:0] in_action,
  input  wire  [smt_pkg::IN_VALUE_W-1:0] in_value,
  output logic                         out_valid,
  input  wire                          out_stall,
  output logic                         out_was_present,
  output logic [REPEAT_BITS:0]         out_occurrences,
  output logic [smt_pkg::STATUS_W-1:0] out_status,
  output logic [CNT_W-1:0]             out_entries_in_use,
  input  wire                          any_eq,
  input  wire  [REPEAT_BITS-1:0]       hit_repeats,
  output smt_pkg::cell_ctl_t           cell_ctl,
  output logic [VALUE_BITS-1:0]        req_value,
  output logic [CNT_W-1:0]             used_count
);
  import smt_pkg::*;

  localparam int OCC_W = REPEAT_BITS + 1;
  localparam logic [REPEAT_BITS-1:0] REP_MAX = '1;

  state_t                  state_r, state_nxt;
  action_t                 action_r;
  logic [VALUE_BITS-1:0]   value_r;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic                    out_valid_r;
  logic                    present_r;
  logic [OCC_W-1:0]        occ_r, occ_nxt;
  status_t                 status_r, status_nxt;
  logic [CNT_W-1:0]        entries_r;
  logic                    accept, can_finish, finish;
  cell_op_t                op;
  logic [63:0]             value_ext;

  // sign-extend the input word, then keep the table's value width
  assign value_ext = {{(64 - IN_VALUE_W){in_value[IN_VALUE_W-1]}}, in_value};

  assign can_finish = !out_valid_r || !out_stall;
  assign in_stall   = !((state_r == S_IDLE) || ((state_r == S_UPD) && can_finish));
  assign accept     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    finish     = 1'b0;
    op         = OP_HOLD;
    occ_nxt    = '0;
    status_nxt = ST_DONE;
    count_nxt  = count_r;
    case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_CMP;
      end
      S_CMP: begin
        state_nxt = S_UPD;
      end
      S_UPD: begin
        if (can_finish) begin
          finish    = 1'b1;
          state_nxt = accept ? S_CMP : S_IDLE;
        end
        case (action_r)
          ACT_INSERT: begin
            if (any_eq) begin
              if (hit_repeats == REP_MAX) begin
                status_nxt = ST_SATURATED;
                occ_nxt    = {1'b0, hit_repeats} + OCC_W'(1);
              end else begin
                op      = OP_INC;
                occ_nxt = {1'b0, hit_repeats} + OCC_W'(2);
              end
            end else if (count_r == CNT_W'(TABLE_DEPTH)) begin
              status_nxt = ST_FULL;
            end else begin
              op        = OP_INSERT;
              count_nxt = count_r + CNT_W'(1);
              occ_nxt   = OCC_W'(1);
            end
          end
          ACT_DELETE: begin
            if (!any_eq) begin
              status_nxt = ST_DEL_ABSENT;
            end else if (hit_repeats != '0) begin
              op      = OP_DEC;
              occ_nxt = {1'b0, hit_repeats};
            end else begin
              op        = OP_REMOVE;
              count_nxt = count_r - CNT_W'(1);
            end
          end
          default: begin
            // find, and the spare code behaves the same
            if (any_eq) occ_nxt = {1'b0, hit_repeats} + OCC_W'(1);
          end
        endcase
        if (!can_finish) begin
          op        = OP_HOLD;
          count_nxt = count_r;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (finish)         out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      action_r <= action_t'(in_action);
      value_r  <= value_ext[VALUE_BITS-1:0];
    end
    if (finish) begin
      present_r <= any_eq;
      occ_r     <= occ_nxt;
      status_r  <= status_nxt;
      entries_r <= count_nxt;
    end
  end

  assign cell_ctl.cmp_en = (state_r == S_CMP);
  assign cell_ctl.op     = op;
  assign req_value       = value_r;
  assign used_count      = count_r;

  assign out_valid          = out_valid_r;
  assign out_was_present    = present_r;
  assign out_occurrences    = occ_r;
  assign out_status         = status_r;
  assign out_entries_in_use = entries_r;

endmodule

`default_nettype wire

>>> rtl/sorted_multiset_table_top.sv
// Top level of the sorted multiset table: sequencer and the row of table cells.
// Depends on smt_pkg, smt_ctrl and smt_cell.
`default_nettype none

// Keeps up to TABLE_DEPTH distinct signed values in ascending order, each with
// a repeat count, in a row of cells that compare against a broadcast request
// and shift into their neighbours. Every request word gives one result word.
// A request is worked in a compare step, in which every cell compares its
// entry with the request and registers its flags, and then an update step,
// in which the sequencer picks the operation and all cells update together
// while the result is loaded into the output register. A stalled output
// register holds the update step. A new word is accepted while idle or in
// the update step that finishes the last one. No clearing pass after reset.
module sorted_multiset_table_top #(
  parameter int TABLE_DEPTH = smt_pkg::DEF_TABLE_DEPTH,
  parameter int VALUE_BITS  = smt_pkg::DEF_VALUE_BITS,
  parameter int REPEAT_BITS = smt_pkg::DEF_REPEAT_BITS,
  parameter int CNT_W       = $clog2(TABLE_DEPTH + 1)
) (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            in_valid,
  output logic                           in_stall,
  input  wire  [smt_pkg::ACTION_W-1:0]   in_action,
  input  wire  [smt_pkg::IN_VALUE_W-1:0] in_value,
  output logic                           out_valid,
  input  wire                            out_stall,
  output logic                           out_was_present,
  output logic [REPEAT_BITS:0]           out_occurrences,
  output logic [smt_pkg::STATUS_W-1:0]   out_status,
  output logic [CNT_W-1:0]               out_entries_in_use
);
  import smt_pkg::*;

  cell_ctl_t              cell_ctl;
  logic [VALUE_BITS-1:0]  req_value;
  logic [CNT_W-1:0]       used_count;
  logic [VALUE_BITS-1:0]  cell_value   [TABLE_DEPTH];
  logic [REPEAT_BITS-1:0] cell_repeats [TABLE_DEPTH];
  logic [REPEAT_BITS-1:0] cell_hit     [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] cell_lt, cell_eq;
  logic                   any_eq;
  logic [REPEAT_BITS-1:0] hit_repeats;

  smt_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .VALUE_BITS  (VALUE_BITS),
    .REPEAT_BITS (REPEAT_BITS),
    .CNT_W       (CNT_W)
  ) u_ctrl (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_action          (in_action),
    .in_value           (in_value),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_was_present    (out_was_present),
    .out_occurrences    (out_occurrences),
    .out_status         (out_status),
    .out_entries_in_use (out_entries_in_use),
    .any_eq             (any_eq),
    .hit_repeats        (hit_repeats),
    .cell_ctl           (cell_ctl),
    .req_value          (req_value),
    .used_count         (used_count)
  );

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    logic [VALUE_BITS-1:0]  l_value, r_value;
    logic [REPEAT_BITS-1:0] l_repeats, r_repeats;
    logic                   l_lt;

    // the first cell sees everything left of it as below the request
    if (g == 0) begin : g_first
      assign l_value   = cell_value[g];
      assign l_repeats = cell_repeats[g];
      assign l_lt      = 1'b1;
    end else begin : g_mid
      assign l_value   = cell_value[g-1];
      assign l_repeats = cell_repeats[g-1];
      assign l_lt      = cell_lt[g-1];
    end

    if (g == TABLE_DEPTH - 1) begin : g_last
      assign r_value   = cell_value[g];
      assign r_repeats = cell_repeats[g];
    end else begin : g_inner
      assign r_value   = cell_value[g+1];
      assign r_repeats = cell_repeats[g+1];
    end

    smt_cell #(
      .INDEX       (g),
      .VALUE_BITS  (VALUE_BITS),
      .REPEAT_BITS (REPEAT_BITS),
      .CNT_W       (CNT_W)
    ) u_cell (
      .clk           (clk),
      .ctl           (cell_ctl),
      .req_value     (req_value),
      .used_count    (used_count),
      .left_value    (l_value),
      .left_repeats  (l_repeats),
      .left_lt       (l_lt),
      .right_value   (r_value),
      .right_repeats (r_repeats),
      .cell_value    (cell_value[g]),
      .cell_repeats  (cell_repeats[g]),
      .lt            (cell_lt[g]),
      .eq            (cell_eq[g]),
      .hit_repeats   (cell_hit[g])
    );
  end

  // at most one cell matches, so its masked count is an OR over the row
  always_comb begin
    hit_repeats = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      hit_repeats = hit_repeats | cell_hit[i];
    end
  end

  assign any_eq = |cell_eq;

endmodule

`default_nettype wire

>>> rtl/smt_checker.sv
// Port-level checks for the sorted multiset table, bound to the top level.
// Depends on smt_pkg and sorted_multiset_table_top.
`default_nettype none

module smt_checker #(
  parameter int TABLE_DEPTH = smt_pkg::DEF_TABLE_DEPTH,
  parameter int REPEAT_BITS = smt_pkg::DEF_REPEAT_BITS,
  parameter int CNT_W       = $clog2(TABLE_DEPTH + 1)
) (
  input wire                          clk,
  input wire                          rst_n,
  input wire                          out_valid,
  input wire                          out_stall,
  input wire                          out_was_present,
  input wire [REPEAT_BITS:0]          out_occurrences,
  input wire [smt_pkg::STATUS_W-1:0]  out_status,
  input wire [CNT_W-1:0]              out_entries_in_use
);
  import smt_pkg::*;

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result word dropped while stalled");

  a_hold_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_occurrences) && $stable(out_status)
      && $stable(out_entries_in_use) && $stable(out_was_present))
    else $error("result word changed while stalled");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_entries_in_use <= CNT_W'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_full_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_FULL) |->
      (out_entries_in_use == CNT_W'(TABLE_DEPTH)) && !out_was_present
      && (out_occurrences == '0))
    else $error("table-full result inconsistent");

  a_absent_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_DEL_ABSENT || !out_was_present) |->
      (out_occurrences <= (REPEAT_BITS + 1)'(1)))
    else $error("absent value reported with repeats");

endmodule

bind sorted_multiset_table_top smt_checker #(
  .TABLE_DEPTH (TABLE_DEPTH),
  .REPEAT_BITS (REPEAT_BITS),
  .CNT_W       (CNT_W)
) u_smt_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_was_present    (out_was_present),
  .out_occurrences    (out_occurrences),
  .out_status         (out_status),
  .out_entries_in_use (out_entries_in_use)
);

`default_nettype wire
